>>> design/qdc_pkg.sv
// Shared types, codes and the Gray-code step table for the quadrature detent counter.
package qdc_pkg;

	localparam int unsigned POS_W   = 32;
	localparam int unsigned EXT_W   = POS_W + 2;
	localparam int unsigned SCALE_W = 31;
	localparam int unsigned ACC_W   = 4;
	localparam int unsigned CIDX_W  = 3;

	localparam logic [SCALE_W-1:0] SCALE_MIN = SCALE_W'(1);
	localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(2147183647);

	localparam logic signed [ACC_W-1:0] DETENT_UP   = ACC_W'(4);
	localparam logic signed [ACC_W-1:0] DETENT_DOWN = -ACC_W'(4);

	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_LOAD   = 2'd1,
		ACT_READ   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_STEP_SCALE    = 3'd0,
		REG_COUNT_FORWARD = 3'd1,
		REG_LIMIT_ENABLE  = 3'd2,
		REG_LOWER_LIMIT   = 3'd3,
		REG_UPPER_LIMIT   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]              action;
		logic                    line_a;
		logic                    line_b;
		logic signed [POS_W-1:0] load_value;
	} in_req_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position_now;
		logic                    stepped;
		logic                    motion_seen;
	} out_rsp_t;

	// Gray order 00 -> 01 -> 11 -> 10 -> 00 is +1; reverse is -1; repeat or jump is 0.
	function automatic logic signed [1:0] gray_delta(input logic [1:0] from_code,
			input logic [1:0] to_code);
		logic signed [1:0] d;
		unique case ({from_code, to_code})
			4'b0001, 4'b0111, 4'b1000, 4'b1110: d = 2'sb01;
			4'b0010, 4'b0100, 4'b1011, 4'b1101: d = 2'sb11;
			default:                            d = 2'sb00;
		endcase
		return d;
	endfunction

endpackage

>>> design/quadrature_detent_counter_top.sv
// Top level of the quadrature detent counter: request register, update logic, result register.
//
// Usage notes:
// - Input channel (in_valid / in_stall / in_req): one request per sample of the
//   two encoder lines, or a position load, or a read-and-clear of the motion flag.
// - Output channel (out_valid / out_stall / out_rsp): exactly one response per
//   request, in request order: position after the request, a detent-completed
//   bit and the motion flag as it was before a read-and-clear.
// - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
//   always high; write only while no request is in flight.
// - A request passes through the request register, then the result register.
//   Throughput: one request per cycle while in_stall is low; the position adder,
//   limit compares and step table all fit between the request register and the
//   result register.
// - Reset (arst_n low) clears position, line history, step count, motion flag,
//   both valid bits and the config registers to their defaults.
// - A stalled response holds its payload; the request register keeps taking a
//   new request as long as it can move into the result register, so in_stall
//   is high only while both stages are full and the output is stalled.
module quadrature_detent_counter_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  qdc_pkg::in_req_t            in_req,
	output logic                        out_valid,
	input  logic                        out_stall,
	output qdc_pkg::out_rsp_t           out_rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [qdc_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [qdc_pkg::POS_W-1:0]   cfg_data
);

	// config registers
	logic [qdc_pkg::SCALE_W-1:0]      step_scale_q;
	logic                             count_forward_q;
	logic                             limit_enable_q;
	logic signed [qdc_pkg::POS_W-1:0] lower_limit_q;
	logic signed [qdc_pkg::POS_W-1:0] upper_limit_q;

	// block state
	logic signed [qdc_pkg::POS_W-1:0] position_q;
	logic [1:0]                       prev_lines_q;
	logic signed [qdc_pkg::ACC_W-1:0] step_acc_q;
	logic                             motion_q;

	// pipeline
	logic                 valid_s1;
	qdc_pkg::in_req_t     req_s1;
	logic                 out_valid_q;
	qdc_pkg::out_rsp_t    rsp_q;

	logic in_accept;
	logic advance;

	// update logic
	logic [1:0]                       lines_now;
	logic signed [1:0]                delta;
	logic signed [qdc_pkg::ACC_W-1:0] acc_sum;
	logic                             hit_up;
	logic                             hit_down;
	logic                             neg_move;
	logic signed [qdc_pkg::EXT_W-1:0] amount;
	logic signed [qdc_pkg::EXT_W-1:0] pos_sum;
	logic signed [qdc_pkg::EXT_W-1:0] lo_ext;
	logic signed [qdc_pkg::EXT_W-1:0] hi_ext;
	logic signed [qdc_pkg::POS_W-1:0] moved_pos;

	logic signed [qdc_pkg::POS_W-1:0] position_d;
	logic [1:0]                       prev_lines_d;
	logic signed [qdc_pkg::ACC_W-1:0] step_acc_d;
	logic                             motion_d;
	qdc_pkg::out_rsp_t                rsp_d;

	logic [qdc_pkg::SCALE_W-1:0]      scale_wr;

	assign cfg_ready = 1'b1;
	assign in_stall  = valid_s1 & out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;
	assign advance   = valid_s1 & (~out_valid_q | ~out_stall);
	assign out_valid = out_valid_q;
	assign out_rsp   = rsp_q;

	// step_scale write is clamped into 1..max
	always_comb begin
		scale_wr = cfg_data[qdc_pkg::SCALE_W-1:0];
		if (scale_wr < qdc_pkg::SCALE_MIN) begin
			scale_wr = qdc_pkg::SCALE_MIN;
		end else if (scale_wr > qdc_pkg::SCALE_MAX) begin
			scale_wr = qdc_pkg::SCALE_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_scale_q    <= qdc_pkg::SCALE_MIN;
			count_forward_q <= 1'b1;
			limit_enable_q  <= 1'b0;
			lower_limit_q   <= '0;
			upper_limit_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				qdc_pkg::REG_STEP_SCALE:    step_scale_q    <= scale_wr;
				qdc_pkg::REG_COUNT_FORWARD: count_forward_q <= cfg_data[0];
				qdc_pkg::REG_LIMIT_ENABLE:  limit_enable_q  <= cfg_data[0];
				qdc_pkg::REG_LOWER_LIMIT:   lower_limit_q   <= cfg_data;
				qdc_pkg::REG_UPPER_LIMIT:   upper_limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Detent move: reaching +4 moves by -scale*dir, reaching -4 by +scale*dir.
	// Sum is kept two bits wider so the clamp compares see the exact value.
	always_comb begin
		lines_now = {req_s1.line_a, req_s1.line_b};
		delta     = qdc_pkg::gray_delta(prev_lines_q, lines_now);
		acc_sum   = step_acc_q + qdc_pkg::ACC_W'(delta);
		hit_up    = (acc_sum == qdc_pkg::DETENT_UP);
		hit_down  = (acc_sum == qdc_pkg::DETENT_DOWN);
		neg_move  = ~count_forward_q ^ hit_up;
		amount    = neg_move ? -$signed({3'b000, step_scale_q}) : $signed({3'b000, step_scale_q});
		pos_sum   = qdc_pkg::EXT_W'(position_q) + amount;
		lo_ext    = qdc_pkg::EXT_W'(lower_limit_q);
		hi_ext    = qdc_pkg::EXT_W'(upper_limit_q);
		if (!limit_enable_q) begin
			moved_pos = pos_sum[qdc_pkg::POS_W-1:0];
		end else if (pos_sum < lo_ext) begin
			moved_pos = lower_limit_q;
		end else if (pos_sum > hi_ext) begin
			moved_pos = upper_limit_q;
		end else begin
			moved_pos = pos_sum[qdc_pkg::POS_W-1:0];
		end
	end

	always_comb begin
		position_d   = position_q;
		prev_lines_d = prev_lines_q;
		step_acc_d   = step_acc_q;
		motion_d     = motion_q;
		rsp_d        = '0;
		unique case (qdc_pkg::action_t'(req_s1.action))
			qdc_pkg::ACT_SAMPLE: begin
				prev_lines_d = lines_now;
				if (hit_up || hit_down) begin
					position_d    = moved_pos;
					step_acc_d    = '0;
					motion_d      = 1'b1;
					rsp_d.stepped = 1'b1;
				end else begin
					step_acc_d = acc_sum;
				end
			end
			qdc_pkg::ACT_LOAD: begin
				position_d = req_s1.load_value;   // never clamped
			end
			qdc_pkg::ACT_READ: begin
				rsp_d.motion_seen = motion_q;
				motion_d          = 1'b0;
			end
			default: ;   // unknown action leaves state alone
		endcase
		rsp_d.position_now = position_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= '0;
			prev_lines_q <= '0;
			step_acc_q   <= '0;
			motion_q     <= 1'b0;
		end else if (advance) begin
			position_q   <= position_d;
			prev_lines_q <= prev_lines_d;
			step_acc_q   <= step_acc_d;
			motion_q     <= motion_d;
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_s1 <= in_req;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

>>> design/qdc_checker.sv
// Port-level checks for the quadrature detent counter, bound to the top level.
module qdc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input qdc_pkg::out_rsp_t out_rsp
);

	// reset empties the result register
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("out_valid high after reset");

	// input backs up only when the output is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled response");

	// a stalled request stays offered
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> in_valid)
		else $error("stalled request dropped");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled response dropped");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_rsp))
		else $error("stalled response changed");

endmodule

bind quadrature_detent_counter_top qdc_checker u_qdc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_rsp   (out_rsp)
);
